// ===== src/ctl_pkg.sv =====
package ctl_pkg;

	// default widths of positions and line/column counters
	localparam int POSITION_BITS_DEF = 20;
	localparam int LINE_BITS_DEF     = 16;
	localparam int KIND_BITS         = 4;
	localparam int KW_BITS           = 4;

	// scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_MINUS,
		MODE_INT,
		MODE_DEC,
		MODE_BAD,
		MODE_IDENT,
		MODE_STR,
		MODE_COMMENT
	} ctl_mode_t;

	// token kinds; punctuation order matches the record codes
	typedef enum logic [KIND_BITS-1:0] {
		KIND_LBRACE,
		KIND_RBRACE,
		KIND_LBRACKET,
		KIND_RBRACKET,
		KIND_COLON,
		KIND_COMMA,
		KIND_STRING,
		KIND_INT,
		KIND_DEC,
		KIND_IDENT,
		KIND_BOOL,
		KIND_UNKNOWN,
		KIND_UNTERM,
		KIND_BADNUM,
		KIND_EOF
	} ctl_kind_t;

	// keyword tracker: 1..4 follow "true", 5..9 follow "false"
	typedef logic [KW_BITS-1:0] ctl_kw_t;
	localparam ctl_kw_t KW_NONE  = 4'd0;
	localparam ctl_kw_t KW_T     = 4'd1;
	localparam ctl_kw_t KW_TR    = 4'd2;
	localparam ctl_kw_t KW_TRU   = 4'd3;
	localparam ctl_kw_t KW_TRUE  = 4'd4;
	localparam ctl_kw_t KW_F     = 4'd5;
	localparam ctl_kw_t KW_FA    = 4'd6;
	localparam ctl_kw_t KW_FAL   = 4'd7;
	localparam ctl_kw_t KW_FALS  = 4'd8;
	localparam ctl_kw_t KW_FALSE = 4'd9;

	// characters of interest
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// records handed from the scanner to the output queue per request
	localparam int RECS_PER_REQ = 2;

endpackage

// ===== src/ctl_lexer.sv =====
module ctl_lexer #(
	parameter int POSITION_BITS = ctl_pkg::POSITION_BITS_DEF,
	parameter int LINE_BITS     = ctl_pkg::LINE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  logic                     action,
	input  logic [7:0]               char_byte,
	output logic [1:0]               rec_cnt,
	output ctl_pkg::ctl_kind_t       rec_kind   [ctl_pkg::RECS_PER_REQ],
	output logic [LINE_BITS-1:0]     rec_line   [ctl_pkg::RECS_PER_REQ],
	output logic [LINE_BITS-1:0]     rec_column [ctl_pkg::RECS_PER_REQ],
	output logic [POSITION_BITS-1:0] rec_offset [ctl_pkg::RECS_PER_REQ],
	output logic [POSITION_BITS-1:0] rec_length [ctl_pkg::RECS_PER_REQ]
);
	import ctl_pkg::*;

	localparam logic [LINE_BITS-1:0]     LIN_MAX = '1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [LINE_BITS-1:0]     LIN_ONE = LINE_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	// scanner state
	ctl_mode_t                mode_q;
	ctl_kw_t                  kw_q;
	logic [LINE_BITS-1:0]     line_q, col_q, oline_q, ocol_q;
	logic [POSITION_BITS-1:0] pos_q, ostart_q;

	ctl_mode_t                mode_d;
	ctl_kw_t                  kw_d;
	logic [LINE_BITS-1:0]     line_d, col_d, oline_d, ocol_d;
	logic [POSITION_BITS-1:0] pos_d, ostart_d;

	// character classes
	logic c_digit, c_alpha, c_word, c_dot, c_blank, c_punct, c_opens;
	ctl_kind_t punct_kind;
	logic consumed;
	logic [POSITION_BITS-1:0] open_len;

	// first record (flushed or closed token) and second record (new token or eof)
	logic                     ra_v, rb_v;
	ctl_kind_t                ra_kind, rb_kind;
	logic [LINE_BITS-1:0]     ra_line, ra_col, rb_line, rb_col;
	logic [POSITION_BITS-1:0] ra_off, ra_len, rb_off, rb_len;

	function automatic ctl_kw_t kw_next(input ctl_kw_t k, input logic [7:0] c);
		ctl_kw_t r;
		r = KW_NONE;
		case (k)
			KW_T:    if (c == "r") r = KW_TR;
			KW_TR:   if (c == "u") r = KW_TRU;
			KW_TRU:  if (c == "e") r = KW_TRUE;
			KW_F:    if (c == "a") r = KW_FA;
			KW_FA:   if (c == "l") r = KW_FAL;
			KW_FAL:  if (c == "s") r = KW_FALS;
			KW_FALS: if (c == "e") r = KW_FALSE;
			default: r = KW_NONE;
		endcase
		return r;
	endfunction

	// classify the byte
	always_comb begin
		c_digit = (char_byte >= "0") && (char_byte <= "9");
		c_alpha = ((char_byte >= "a") && (char_byte <= "z")) ||
		          ((char_byte >= "A") && (char_byte <= "Z"));
		c_word  = c_alpha || c_digit || (char_byte == CH_UNDER);
		c_dot   = (char_byte == CH_DOT);
		c_blank = (char_byte == CH_NL) || (char_byte == CH_SPACE) ||
		          (char_byte == CH_TAB) || (char_byte == CH_CR);
		c_punct = 1'b1;
		case (char_byte)
			CH_LBRACE: punct_kind = KIND_LBRACE;
			CH_RBRACE: punct_kind = KIND_RBRACE;
			CH_LBRACK: punct_kind = KIND_LBRACKET;
			CH_RBRACK: punct_kind = KIND_RBRACKET;
			CH_COLON:  punct_kind = KIND_COLON;
			CH_COMMA:  punct_kind = KIND_COMMA;
			default: begin
				punct_kind = KIND_UNKNOWN;
				c_punct    = 1'b0;
			end
		endcase
		c_opens = (char_byte == CH_HASH) || (char_byte == CH_QUOTE) ||
		          (char_byte == CH_MINUS) || c_word;
		open_len = pos_q - ostart_q;
	end

	// does the open token take this byte
	always_comb begin
		case (mode_q)
			MODE_MINUS:   consumed = c_digit;
			MODE_INT:     consumed = c_digit || c_dot;
			MODE_DEC:     consumed = c_digit || c_dot;
			MODE_BAD:     consumed = c_digit || c_dot;
			MODE_IDENT:   consumed = c_word;
			MODE_STR:     consumed = 1'b1;
			MODE_COMMENT: consumed = (char_byte != CH_NL);
			default:      consumed = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		mode_d   = mode_q;
		kw_d     = kw_q;
		ostart_d = ostart_q;
		oline_d  = oline_q;
		ocol_d   = ocol_q;
		if (consumed) begin
			case (mode_q)
				MODE_MINUS: mode_d = MODE_INT;
				MODE_INT:   if (c_dot) mode_d = MODE_DEC;
				MODE_DEC:   if (c_dot) mode_d = MODE_BAD;
				MODE_IDENT: kw_d = kw_next(kw_q, char_byte);
				MODE_STR:   if (char_byte == CH_QUOTE) mode_d = MODE_IDLE;
				default:    mode_d = mode_q;
			endcase
		end else begin
			mode_d = MODE_IDLE;
			if (char_byte == CH_HASH) begin
				mode_d = MODE_COMMENT;
			end else if (char_byte == CH_QUOTE) begin
				mode_d = MODE_STR;
			end else if (char_byte == CH_MINUS) begin
				mode_d = MODE_MINUS;
			end else if (c_digit) begin
				mode_d = MODE_INT;
			end else if (c_word) begin
				mode_d = MODE_IDENT;
				if (char_byte == "t") kw_d = KW_T;
				else if (char_byte == "f") kw_d = KW_F;
				else kw_d = KW_NONE;
			end
			if ((char_byte != CH_HASH) && c_opens) begin
				ostart_d = pos_q;
				oline_d  = line_q;
				ocol_d   = col_q;
			end
		end
		// position of the next byte
		if (char_byte == CH_NL) begin
			line_d = (line_q == LIN_MAX) ? line_q : line_q + LIN_ONE;
			col_d  = LIN_ONE;
		end else begin
			line_d = line_q;
			col_d  = (col_q == LIN_MAX) ? col_q : col_q + LIN_ONE;
		end
		pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
		// end of content returns to reset state
		if (action) begin
			mode_d   = MODE_IDLE;
			kw_d     = KW_NONE;
			line_d   = LIN_ONE;
			col_d    = LIN_ONE;
			pos_d    = '0;
			ostart_d = '0;
			oline_d  = LIN_ONE;
			ocol_d   = LIN_ONE;
		end
	end

	// records produced by this request
	always_comb begin
		ra_v    = 1'b0;
		ra_kind = KIND_UNKNOWN;
		ra_line = oline_q;
		ra_col  = ocol_q;
		ra_off  = ostart_q;
		ra_len  = open_len;
		rb_v    = 1'b0;
		rb_kind = KIND_UNKNOWN;
		rb_line = line_q;
		rb_col  = col_q;
		rb_off  = pos_q;
		rb_len  = POS_ONE;
		if (action || !consumed) begin
			// flush of the open token
			case (mode_q)
				MODE_MINUS: begin
					ra_v    = 1'b1;
					ra_len  = POS_ONE;
				end
				MODE_INT: begin
					ra_v    = 1'b1;
					ra_kind = KIND_INT;
				end
				MODE_DEC: begin
					ra_v    = 1'b1;
					ra_kind = KIND_DEC;
				end
				MODE_BAD: begin
					ra_v    = 1'b1;
					ra_kind = KIND_BADNUM;
				end
				MODE_IDENT: begin
					ra_v    = 1'b1;
					ra_kind = ((kw_q == KW_TRUE) || (kw_q == KW_FALSE)) ? KIND_BOOL : KIND_IDENT;
				end
				MODE_STR: begin
					ra_v    = action;
					ra_kind = KIND_UNTERM;
				end
				default: ra_v = 1'b0;
			endcase
		end else if ((mode_q == MODE_STR) && (char_byte == CH_QUOTE)) begin
			// closing quote, length counts both quotes
			ra_v    = 1'b1;
			ra_kind = KIND_STRING;
			ra_len  = open_len + POS_ONE;
		end
		if (action) begin
			rb_v    = 1'b1;
			rb_kind = KIND_EOF;
			rb_len  = '0;
		end else if (!consumed) begin
			if (c_punct) begin
				rb_v    = 1'b1;
				rb_kind = punct_kind;
			end else if (!c_blank && !c_opens) begin
				rb_v    = 1'b1;
				rb_kind = KIND_UNKNOWN;
			end
		end
	end

	// pack the valid records to the front
	always_comb begin
		if (ra_v) begin
			rec_cnt       = rb_v ? 2'd2 : 2'd1;
			rec_kind[0]   = ra_kind;
			rec_line[0]   = ra_line;
			rec_column[0] = ra_col;
			rec_offset[0] = ra_off;
			rec_length[0] = ra_len;
		end else begin
			rec_cnt       = {1'b0, rb_v};
			rec_kind[0]   = rb_kind;
			rec_line[0]   = rb_line;
			rec_column[0] = rb_col;
			rec_offset[0] = rb_off;
			rec_length[0] = rb_len;
		end
		rec_kind[1]   = rb_kind;
		rec_line[1]   = rb_line;
		rec_column[1] = rb_col;
		rec_offset[1] = rb_off;
		rec_length[1] = rb_len;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			kw_q     <= KW_NONE;
			line_q   <= LIN_ONE;
			col_q    <= LIN_ONE;
			pos_q    <= '0;
			ostart_q <= '0;
			oline_q  <= LIN_ONE;
			ocol_q   <= LIN_ONE;
		end else if (take) begin
			mode_q   <= mode_d;
			kw_q     <= kw_d;
			line_q   <= line_d;
			col_q    <= col_d;
			pos_q    <= pos_d;
			ostart_q <= ostart_d;
			oline_q  <= oline_d;
			ocol_q   <= ocol_d;
		end
	end

endmodule

// ===== src/config_text_lexer.sv =====
// Streaming lexer for JSON-like configuration text with hash comments.
// Request channel (req_valid / req_stall): one item per accepted edge, either
// a content byte (action = 0, char_byte) or the end of content (action = 1).
// Token channel (tok_valid / tok_stall): one token record per accepted edge,
// giving kind, line, column, byte offset and length of the token;
// last_of_run marks the final record caused by one request.
// A request yields zero, one or two records, which are written into the
// output queue on the edge that accepts the request.
// Throughput: one request per cycle while req_stall is low. Records leave
// through a four-entry queue at one per cycle; req_stall rises while three
// or more records wait, so runs of two-record requests are paced by the
// token side. While tok_stall is high the head record holds steady and the
// queue fills, then req_stall holds the request side. Nothing is dropped.
// End of content flushes any open token, emits an end-of-file record and
// returns the scanner to line 1, column 1, offset 0.
// Reset (arst_n low) empties the queue and puts the scanner in that same state.
module config_text_lexer #(
	parameter int POSITION_BITS = ctl_pkg::POSITION_BITS_DEF,
	parameter int LINE_BITS     = ctl_pkg::LINE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            action,
	input  logic [7:0]                      char_byte,
	output logic                            tok_valid,
	input  logic                            tok_stall,
	output logic [ctl_pkg::KIND_BITS-1:0]   token_kind,
	output logic [LINE_BITS-1:0]            token_line,
	output logic [LINE_BITS-1:0]            token_column,
	output logic [POSITION_BITS-1:0]        token_offset,
	output logic [POSITION_BITS-1:0]        token_length,
	output logic                            last_of_run
);
	import ctl_pkg::*;

	localparam int DEPTH   = 4;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_AT = CNT_W'(DEPTH - RECS_PER_REQ + 1);

	logic take, pop;
	logic [1:0] rec_cnt;
	ctl_kind_t                rec_kind   [RECS_PER_REQ];
	logic [LINE_BITS-1:0]     rec_line   [RECS_PER_REQ];
	logic [LINE_BITS-1:0]     rec_column [RECS_PER_REQ];
	logic [POSITION_BITS-1:0] rec_offset [RECS_PER_REQ];
	logic [POSITION_BITS-1:0] rec_length [RECS_PER_REQ];

	// output queue
	ctl_kind_t                q_kind   [DEPTH];
	logic [LINE_BITS-1:0]     q_line   [DEPTH];
	logic [LINE_BITS-1:0]     q_column [DEPTH];
	logic [POSITION_BITS-1:0] q_offset [DEPTH];
	logic [POSITION_BITS-1:0] q_length [DEPTH];
	logic                     q_last   [DEPTH];
	logic [PTR_W-1:0]         head_q, tail_q, tail_nx;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         push_n;

	ctl_lexer #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.action(action),
		.char_byte(char_byte),
		.rec_cnt(rec_cnt),
		.rec_kind(rec_kind),
		.rec_line(rec_line),
		.rec_column(rec_column),
		.rec_offset(rec_offset),
		.rec_length(rec_length)
	);

	// handshakes
	assign req_stall = (count_q >= FULL_AT);
	assign take      = req_valid && !req_stall;
	assign tok_valid = (count_q != '0);
	assign pop       = tok_valid && !tok_stall;
	assign push_n    = take ? CNT_W'(rec_cnt) : '0;
	assign tail_nx   = tail_q + PTR_W'(1);

	// head record drives the token port
	assign token_kind   = q_kind[head_q];
	assign token_line   = q_line[head_q];
	assign token_column = q_column[head_q];
	assign token_offset = q_offset[head_q];
	assign token_length = q_length[head_q];
	assign last_of_run  = q_last[head_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (take && (rec_cnt != 2'd0)) begin
			q_kind[tail_q]   <= rec_kind[0];
			q_line[tail_q]   <= rec_line[0];
			q_column[tail_q] <= rec_column[0];
			q_offset[tail_q] <= rec_offset[0];
			q_length[tail_q] <= rec_length[0];
			q_last[tail_q]   <= (rec_cnt == 2'd1);
		end
		if (take && (rec_cnt == 2'd2)) begin
			q_kind[tail_nx]   <= rec_kind[1];
			q_line[tail_nx]   <= rec_line[1];
			q_column[tail_nx] <= rec_column[1];
			q_offset[tail_nx] <= rec_offset[1];
			q_length[tail_nx] <= rec_length[1];
			q_last[tail_nx]   <= 1'b1;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) head_q <= head_q + PTR_W'(1);
			tail_q  <= tail_q + PTR_W'(push_n);
			count_q <= count_q + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
		end
	end

endmodule

// ===== tb/config_text_lexer_test.sv =====
`timescale 1ns / 100ps

module config_text_lexer_test;
	import ctl_pkg::*;

	localparam logic [15:0] LINE_TOP = 16'hFFFF;
	localparam logic [19:0] POS_TOP = 20'hFFFFF;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 800;
	localparam int TAIL_ITEMS = 100;

	// one pending request for the driver
	typedef struct {
		logic act;
		logic [7:0] ch;
		int gap_pct;
		logic tail;
	} req_t;

	// one token record as the block should report it
	typedef struct {
		ctl_kind_t kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [19:0] offset;
		logic [19:0] length;
		logic last;
	} rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic action = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic tok_valid;
	logic tok_stall = 1'b0;
	logic [KIND_BITS-1:0] token_kind;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic [19:0] token_offset;
	logic [19:0] token_length;
	logic last_of_run;

	config_text_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.char_byte(char_byte),
		.tok_valid(tok_valid),
		.tok_stall(tok_stall),
		.token_kind(token_kind),
		.token_line(token_line),
		.token_column(token_column),
		.token_offset(token_offset),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

	req_t pending[$];
	rec_t tokens_due[$];
	rec_t batch[$];
	int errors = 0;
	int quiet_cycles = 0;
	logic calm_tail = 1'b0;

	// stimulus shaping while the request queue is filled
	int gen_gap = 20;
	logic gen_tail = 1'b0;
	int random_count = 0;

	// scanner state of the predictor
	ctl_mode_t sc_mode = MODE_IDLE;
	logic [15:0] sc_line = 16'd1;
	logic [15:0] sc_col = 16'd1;
	logic [19:0] sc_pos = '0;
	logic [19:0] mark_pos = '0;
	logic [15:0] mark_line = 16'd1;
	logic [15:0] mark_col = 16'd1;
	ctl_kw_t kw_state = KW_NONE;

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [19:0] span();
		return (sc_pos >= mark_pos) ? sc_pos - mark_pos : '0;
	endfunction

	function automatic ctl_kw_t kw_step(input ctl_kw_t k, input logic [7:0] c);
		case (k)
			KW_T: return (c == "r") ? KW_TR : KW_NONE;
			KW_TR: return (c == "u") ? KW_TRU : KW_NONE;
			KW_TRU: return (c == "e") ? KW_TRUE : KW_NONE;
			KW_F: return (c == "a") ? KW_FA : KW_NONE;
			KW_FA: return (c == "l") ? KW_FAL : KW_NONE;
			KW_FAL: return (c == "s") ? KW_FALS : KW_NONE;
			KW_FALS: return (c == "e") ? KW_FALSE : KW_NONE;
			default: return KW_NONE;
		endcase
	endfunction

	task automatic add_rec(input ctl_kind_t kind, input logic [15:0] line,
			input logic [15:0] col, input logic [19:0] off, input logic [19:0] len);
		rec_t r;
		r.kind = kind;
		r.line = line;
		r.column = col;
		r.offset = off;
		r.length = len;
		r.last = 1'b0;
		batch.insert(batch.size(), r);
	endtask

	task automatic open_token(input ctl_mode_t mode);
		sc_mode = mode;
		mark_pos = sc_pos;
		mark_line = sc_line;
		mark_col = sc_col;
	endtask

	// report the open token, if any, and go idle
	task automatic close_token(input logic at_end);
		case (sc_mode)
			MODE_MINUS: add_rec(KIND_UNKNOWN, mark_line, mark_col, mark_pos, 20'd1);
			MODE_INT: add_rec(KIND_INT, mark_line, mark_col, mark_pos, span());
			MODE_DEC: add_rec(KIND_DEC, mark_line, mark_col, mark_pos, span());
			MODE_BAD: add_rec(KIND_BADNUM, mark_line, mark_col, mark_pos, span());
			MODE_IDENT: add_rec((kw_state == KW_TRUE || kw_state == KW_FALSE) ? KIND_BOOL
				: KIND_IDENT, mark_line, mark_col, mark_pos, span());
			MODE_STR: if (at_end) begin
				add_rec(KIND_UNTERM, mark_line, mark_col, mark_pos, span());
			end
			default: ;
		endcase
		sc_mode = MODE_IDLE;
	endtask

	// byte seen with nothing open
	task automatic start_token(input logic [7:0] c);
		case (c)
			CH_NL, CH_SPACE, CH_TAB, CH_CR: ;
			CH_HASH: sc_mode = MODE_COMMENT;
			CH_LBRACE: add_rec(KIND_LBRACE, sc_line, sc_col, sc_pos, 20'd1);
			CH_RBRACE: add_rec(KIND_RBRACE, sc_line, sc_col, sc_pos, 20'd1);
			CH_LBRACK: add_rec(KIND_LBRACKET, sc_line, sc_col, sc_pos, 20'd1);
			CH_RBRACK: add_rec(KIND_RBRACKET, sc_line, sc_col, sc_pos, 20'd1);
			CH_COLON: add_rec(KIND_COLON, sc_line, sc_col, sc_pos, 20'd1);
			CH_COMMA: add_rec(KIND_COMMA, sc_line, sc_col, sc_pos, 20'd1);
			CH_QUOTE: open_token(MODE_STR);
			CH_MINUS: open_token(MODE_MINUS);
			default: begin
				if (is_digit(c)) begin
					open_token(MODE_INT);
				end else if (is_alpha(c) || c == CH_UNDER) begin
					open_token(MODE_IDENT);
					kw_state = (c == "t") ? KW_T : (c == "f") ? KW_F : KW_NONE;
				end else begin
					add_rec(KIND_UNKNOWN, sc_line, sc_col, sc_pos, 20'd1);
				end
			end
		endcase
	endtask

	task automatic scan_byte(input logic [7:0] c);
		logic consumed;
		consumed = 1'b1;
		case (sc_mode)
			MODE_MINUS: if (is_digit(c)) sc_mode = MODE_INT; else consumed = 1'b0;
			MODE_INT: begin
				if (c == CH_DOT) sc_mode = MODE_DEC;
				else if (!is_digit(c)) consumed = 1'b0;
			end
			MODE_DEC: begin
				if (c == CH_DOT) sc_mode = MODE_BAD;
				else if (!is_digit(c)) consumed = 1'b0;
			end
			MODE_BAD: if (!(c == CH_DOT || is_digit(c))) consumed = 1'b0;
			MODE_IDENT: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER) kw_state = kw_step(kw_state, c);
				else consumed = 1'b0;
			end
			MODE_STR: if (c == CH_QUOTE) begin
				add_rec(KIND_STRING, mark_line, mark_col, mark_pos, span() + 20'd1);
				sc_mode = MODE_IDLE;
			end
			MODE_COMMENT: if (c == CH_NL) begin
				sc_mode = MODE_IDLE;
				consumed = 1'b0;
			end
			default: consumed = 1'b0;
		endcase
		if (!consumed) begin
			close_token(1'b0);
			start_token(c);
		end
		// advance position, saturating
		if (c == CH_NL) begin
			if (sc_line != LINE_TOP) sc_line++;
			sc_col = 16'd1;
		end else if (sc_col != LINE_TOP) begin
			sc_col++;
		end
		if (sc_pos != POS_TOP) sc_pos++;
	endtask

	// records caused by one accepted request, queued in order
	task automatic lex_request(input logic act, input logic [7:0] c);
		batch.delete();
		if (act) begin
			close_token(1'b1);
			add_rec(KIND_EOF, sc_line, sc_col, sc_pos, 20'd0);
			sc_mode = MODE_IDLE;
			sc_line = 16'd1;
			sc_col = 16'd1;
			sc_pos = '0;
			mark_pos = '0;
			mark_line = 16'd1;
			mark_col = 16'd1;
			kw_state = KW_NONE;
		end else begin
			scan_byte(c);
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) tokens_due.insert(tokens_due.size(), batch[i]);
	endtask

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic put_byte(input logic [7:0] c);
		req_t r;
		r.act = 1'b0;
		r.ch = c;
		r.gap_pct = gen_gap;
		r.tail = gen_tail;
		pending.insert(pending.size(), r);
		random_count++;
	endtask

	task automatic put_end();
		req_t r;
		r.act = 1'b1;
		r.ch = 8'($urandom_range(0, 255));
		r.gap_pct = gen_gap;
		r.tail = gen_tail;
		pending.insert(pending.size(), r);
		random_count++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++) put_byte(s[i]);
	endtask

	task automatic put_digits(input int lo, input int hi);
		repeat ($urandom_range(lo, hi)) put_byte(8'("0" + $urandom_range(0, 9)));
	endtask

	// one random token-shaped fragment, mostly well formed
	task automatic put_fragment();
		logic [7:0] puncts [6];
		string words [8];
		logic [7:0] c;
		puncts = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA};
		words = '{"true", "false", "tru", "fals", "truex", "false_1", "t", "f"};
		case ($urandom_range(0, 15))
			0, 1, 2: put_byte(puncts[$urandom_range(0, 5)]);
			3, 4: begin
				put_byte(CH_QUOTE);
				repeat ($urandom_range(0, 6)) begin
					c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(8'h20, 8'h7E));
					if (c == CH_QUOTE) c = CH_NL;
					put_byte(c);
				end
				// now and then leave it open to the end of content
				if ($urandom_range(0, 7) == 0) put_end();
				else put_byte(CH_QUOTE);
			end
			5, 6: begin
				if ($urandom_range(0, 2) == 0) put_byte(CH_MINUS);
				put_digits(1, 4);
			end
			7: begin
				if ($urandom_range(0, 3) == 0) put_byte(CH_MINUS);
				put_digits(1, 3);
				put_byte(CH_DOT);
				put_digits(0, 3);
			end
			8: begin
				put_digits(1, 2);
				put_byte(CH_DOT);
				put_digits(0, 2);
				repeat ($urandom_range(1, 3)) begin
					put_byte(CH_DOT);
					put_digits(0, 2);
				end
			end
			9, 10: begin
				c = ($urandom_range(0, 5) == 0) ? CH_UNDER
					: 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
				put_byte(c);
				repeat ($urandom_range(0, 5)) begin
					case ($urandom_range(0, 3))
						0: c = 8'("0" + $urandom_range(0, 9));
						1: c = CH_UNDER;
						2: c = 8'("A" + $urandom_range(0, 25));
						default: c = 8'("a" + $urandom_range(0, 25));
					endcase
					put_byte(c);
				end
			end
			11: put_text(words[$urandom_range(0, 7)]);
			12: begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0: put_byte(CH_SPACE);
						1: put_byte(CH_TAB);
						2: put_byte(CH_CR);
						default: put_byte(CH_NL);
					endcase
				end
			end
			13: begin
				put_byte(CH_HASH);
				repeat ($urandom_range(0, 5)) begin
					c = 8'($urandom_range(0, 255));
					put_byte((c == CH_NL) ? CH_HASH : c);
				end
				put_byte(CH_NL);
			end
			14: begin
				if ($urandom_range(0, 1)) put_byte(CH_MINUS);
				put_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				if ($urandom_range(0, 1)) put_end();
				else put_byte(8'($urandom_range(0, 255)));
			end
		endcase
		if ($urandom_range(0, 1)) put_byte(CH_SPACE);
	endtask

	task automatic fill_requests();
		// directed: every punctuation, string with newline, signed int,
		// decimal, bad number, bool then lone minus then ident at end
		gen_gap = 20;
		put_text("{}[]:,\"\n\"-09,2.5,1.2.3 true-x");
		put_end();
		// false, comment with a high byte, skipped bytes, high and zero
		// bytes as unknowns, unterminated string, then end with nothing open
		put_text("false#");
		put_byte(8'h80);
		put_text("\n\t\r");
		put_byte(8'hFF);
		put_byte(8'h00);
		put_text("\"a");
		put_end();
		put_end();

		// random text, with idling phases changing as it goes
		random_count = 0;
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: gen_gap = 0;
					1: gen_gap = 10;
					default: gen_gap = 30;
				endcase
			end
			put_fragment();
		end
		gen_gap = 0;
		gen_tail = 1'b1;
		while (random_count < RANDOM_ITEMS + TAIL_ITEMS) put_fragment();
		put_end();
	endtask

	// ---------------------------------------------------------------
	// Request driver
	// ---------------------------------------------------------------
	int gap_left = 0;

	always @(posedge clk) begin : drive_requests
		req_t item;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) lex_request(action, char_byte);
			if (req_valid && req_stall) begin
				// stalled: hold the request as it is
			end else if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left--;
			end else if (pending.size() == 0) begin
				req_valid <= 1'b0;
			end else if (req_valid && $urandom_range(0, 99) < pending[0].gap_pct) begin
				req_valid <= 1'b0;
				gap_left = $urandom_range(0, 15);
			end else begin
				item = pending.pop_front();
				req_valid <= 1'b1;
				action <= item.act;
				char_byte <= item.ch;
				calm_tail <= item.tail;
			end
		end
	end

	// ---------------------------------------------------------------
	// Token monitor and output stalls
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [19:0] want,
			input logic [19:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	int stall_left = 0;
	int stall_pct = 10;
	int phase_tick = 0;

	always @(posedge clk) begin : watch_tokens
		rec_t want;
		if (!arst_n) begin
			tok_stall <= 1'b0;
		end else begin
			if (tok_valid && !tok_stall) begin
				if (tokens_due.size() == 0) begin
					$error("token record with nothing expected: kind %0d", token_kind);
					errors++;
				end else begin
					want = tokens_due.pop_front();
					check_field("token_kind", 20'(want.kind), 20'(token_kind));
					check_field("token_line", 20'(want.line), 20'(token_line));
					check_field("token_column", 20'(want.column), 20'(token_column));
					check_field("token_offset", want.offset, token_offset);
					check_field("token_length", want.length, token_length);
					check_field("last_of_run", 20'(want.last), 20'(last_of_run));
				end
			end
			// random stall bursts, with tok_stall always released between bursts
			if (tok_stall && stall_left > 0) begin
				tok_stall <= 1'b1;
				stall_left--;
			end else if (!tok_stall && !calm_tail && $urandom_range(0, 99) < stall_pct) begin
				tok_stall <= 1'b1;
				stall_left = $urandom_range(0, 15);
			end else begin
				tok_stall <= 1'b0;
			end
			phase_tick++;
			if (phase_tick % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 40;
				endcase
			end
		end
	end

	// cycles in which neither side moves anything
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (tok_valid && !tok_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("FAIL config_text_lexer");
		$finish;
	end

	initial begin
		fill_requests();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending.size() != 0 || req_valid) @(posedge clk);
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS config_text_lexer");
		end else begin
			$display("FAIL config_text_lexer");
		end
		$finish;
	end

endmodule

// ===== config_text_lexer.f =====
src/ctl_pkg.sv
src/ctl_lexer.sv
src/config_text_lexer.sv
tb/config_text_lexer_test.sv
